>>> sv/nrt_pkg.sv
// Package for the name registry table: shared types, status codes and the
// name normalization function. Depends on nothing.
package nrt_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 64;
  localparam int unsigned DEF_NAME_BYTES    = 8;
  localparam int unsigned NAME_W            = 64;
  localparam int unsigned ID_W              = 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  localparam int unsigned STATUS_W = $bits(status_e);

  // Query token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [ID_W-1:0]   id;
    logic [NAME_W-1:0] key;
  } tok_t;

  // Keep the first nb bytes up to (not including) the first zero byte.
  function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] key,
                                                  input int unsigned nb);
    logic [NAME_W-1:0] res;
    logic              keep;
    res  = '0;
    keep = 1'b1;
    for (int unsigned b = 0; b < NAME_W / 8; b++) begin
      if (b >= nb || key[8*b +: 8] == 8'h00) begin
        keep = 1'b0;
      end
      if (keep) begin
        res[8*b +: 8] = key[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage

>>> sv/nrt_if.sv
// Valid/ready channel interfaces for requests and responses of the name
// registry table. Depends on nrt_pkg for field widths.
interface nrt_req_if
  import nrt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ID_W-1:0]   requester_id;
  logic [NAME_W-1:0] name_key;

  modport source (output valid, req_type, requester_id, name_key, input ready);
  modport sink   (input valid, req_type, requester_id, name_key, output ready);
endinterface

interface nrt_rsp_if
  import nrt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     found_id;

  modport source (output valid, status, found_id, input ready);
  modport sink   (input valid, status, found_id, output ready);
endinterface

>>> sv/nrt_cell.sv
// One entry cell of the registry chain: holds a name and id, shifts them on
// a register, and checks a passing query token. Depends on nrt_pkg.
module nrt_cell
  import nrt_pkg::*;
#(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [NAME_W-1:0] name_i,
  input  logic [ID_W-1:0]   id_i,
  output logic [NAME_W-1:0] name_o,
  output logic [ID_W-1:0]   id_o,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [NAME_W-1:0] name_q;
  logic [ID_W-1:0]   id_q;
  logic              live;
  tok_t              tok_d, tok_q;

  // The entry is in use only when it sits below the fill count.
  assign live = CNT_W'(IDX) < count_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      name_q <= name_i;
      id_q   <= id_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.hit && live && name_q == tok_i.key) begin
      tok_d.hit = 1'b1;
      tok_d.id  = id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign name_o = name_q;
  assign id_o   = id_q;
  assign tok_o  = tok_q;

endmodule

>>> sv/name_registry_table_top.sv
// Top level of the name registry table: request/response control and the
// chain of entry cells. Depends on nrt_pkg, nrt_if and nrt_cell.
//
// Usage: requests arrive on req_i (valid/ready) and each produces exactly
// one response on rsp_o. A register request stores the requester id under
// the normalized name (bytes past NAME_BYTES or past the first zero byte are
// dropped) and answers ok, or table full when all entries are used. A lookup
// answers with the id of the newest matching entry, or not found.
// The entries live in a row of cells. A register with room shifts every
// entry one cell down and puts the new one in the first cell, so cell order
// is newest first. A lookup sends a query token down the row, one cell per
// cycle; the first live cell that matches marks the token with its id.
// A register answers in the cycle after its transfer; a lookup answers once
// the token has walked the full length of the cell row and its result is
// registered. One request is handled at a time, so a new request is taken
// only after the previous response transfer.
// Reset empties the table at once (the fill count goes to zero); there is
// no clearing pass. While the receiver stalls, the response is held stable
// in its output register and no new request is taken.
module name_registry_table_top
  import nrt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned NAME_BYTES    = DEF_NAME_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nrt_req_if.sink   req_i,
  nrt_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_RESP   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                rsp_vld_q, rsp_vld_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ID_W-1:0]     fid_q, fid_d;

  logic              req_xfer;
  logic              full;
  logic              shift_en;
  logic [NAME_W-1:0] key_norm;

  // Chain links: index k feeds cell k, the last index leaves the row.
  logic [NAME_W-1:0] link_name [TABLE_ENTRIES+1];
  logic [ID_W-1:0]   link_id   [TABLE_ENTRIES+1];
  tok_t              link_tok  [TABLE_ENTRIES+1];

  assign req_i.ready = state_q == S_IDLE;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign full        = cnt_q == CNT_W'(TABLE_ENTRIES);
  assign key_norm    = norm_name(req_i.name_key, NAME_BYTES);
  assign shift_en    = req_xfer && req_i.req_type && !full;

  // Head of the chain: the new entry on a register, a fresh token on a lookup.
  assign link_name[0]    = key_norm;
  assign link_id[0]      = req_i.requester_id;
  assign link_tok[0].vld = req_xfer && !req_i.req_type;
  assign link_tok[0].hit = 1'b0;
  assign link_tok[0].id  = '0;
  assign link_tok[0].key = key_norm;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    nrt_cell #(
      .CNT_W (CNT_W),
      .IDX   (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_en),
      .count_i (cnt_q),
      .name_i  (link_name[k]),
      .id_i    (link_id[k]),
      .name_o  (link_name[k+1]),
      .id_o    (link_id[k+1]),
      .tok_i   (link_tok[k]),
      .tok_o   (link_tok[k+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rsp_vld_d = rsp_vld_q;
    status_d  = status_q;
    fid_d     = fid_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          if (req_i.req_type) begin
            // Register: answer right away; the shift, if the table has room, happens this cycle.
            fid_d     = '0;
            rsp_vld_d = 1'b1;
            state_d   = S_RESP;
            if (full) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_OK;
              cnt_d    = cnt_q + CNT_W'(1);
            end
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (link_tok[TABLE_ENTRIES].vld) begin
          rsp_vld_d = 1'b1;
          state_d   = S_RESP;
          if (link_tok[TABLE_ENTRIES].hit) begin
            status_d = ST_OK;
            fid_d    = link_tok[TABLE_ENTRIES].id;
          end else begin
            status_d = ST_NOT_FOUND;
            fid_d    = '0;
          end
        end
      end
      S_RESP: begin
        if (rsp_o.ready) begin
          rsp_vld_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    fid_q    <= fid_d;
  end

  assign rsp_o.valid    = rsp_vld_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.found_id = fid_q;

endmodule

>>> sv/nrt_checker.sv
// Port-level checks for the name registry table, bound to the top level.
// Depends on nrt_pkg and name_registry_table_top.
module nrt_checker
  import nrt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [ID_W-1:0]     found_id_i
);

  // One request at a time: no new request is taken while a response waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request taken while a response is pending");

  // A response transfer reopens the request side on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i |=> req_ready_i && !rsp_valid_i)
    else $error("block did not return to idle after a response");

  // Only lookups that hit carry an id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_OK |-> found_id_i == '0)
    else $error("nonzero id with a failing status");

  // A stalled response stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
                                    && $stable(found_id_i))
    else $error("stalled response changed");

  // A not found never answers a request transfer at once: a lookup must walk the chain first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !rsp_valid_i || status_i != ST_NOT_FOUND)
    else $error("lookup answered without walking the chain");

endmodule

bind name_registry_table_top nrt_checker u_nrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .found_id_i  (rsp_o.found_id)
);
